@@ design/read_quality_window_trim_defines.svh @@
// ----------------------------------------------------------------------------
// Read quality window trim: assertion macros
// Checks are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef READ_QUALITY_WINDOW_TRIM_DEFINES_SVH
`define READ_QUALITY_WINDOW_TRIM_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RQWT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rqwt check failed");
// next-cycle implication
`define RQWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rqwt check failed");
`else
`define RQWT_ASSERT_NOW(lbl, ante, cons)
`define RQWT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/rqwt_pkg.sv @@
// ----------------------------------------------------------------------------
// Read quality window trim: package
// Controller states, register indexes, field widths and base helpers.
// ----------------------------------------------------------------------------
package rqwt_pkg;

    // summary field width
    localparam int unsigned FIELD_W = 15;

    // mask letter for replace mode
    localparam logic [7:0] MASK_LETTER = 8'h4E;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_SCORE  = 2'd0;
    localparam logic [1:0] CFG_MIN_MATCH  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd2;
    localparam logic [1:0] CFG_LOWER_MODE = 2'd3;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_BASE    = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PRE_RD,
        ST_PRE_US,
        ST_SCAN_RD,
        ST_SCAN_US,
        ST_CS_RD,
        ST_CS_US,
        ST_CE_RD,
        ST_CE_US,
        ST_SUM,
        ST_DRAIN,
        ST_DOUT
    } t_state;

    // lower case letters are stored upper case
    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'd32;
        end
        return r;
    endfunction

    // mask one base: lower-case a letter, or replace by N
    function automatic logic [7:0] mask_base(input logic [7:0] b, input logic lower);
        logic [7:0] r;
        r = b;
        if (lower) begin
            if (b >= 8'h41 && b <= 8'h5A) begin
                r = b + 8'd32;
            end
        end else begin
            r = MASK_LETTER;
        end
        return r;
    endfunction

endpackage

@@ design/read_quality_window_trim.sv @@
// ----------------------------------------------------------------------------
// Read quality window trim
// Sliding-window quality trimmer for one sequencing read held in memory.
// ----------------------------------------------------------------------------
// Loads take one base per cycle into the base and quality memories. The word
// marked last_base starts trimming: one prefill pass over min(window, n)
// qualities, one sliding scan over the n window positions (two quality reads
// per step), then a walk over the low-quality run at the start bound and one
// at the end bound. Each step is a read state then an update state, because
// the memory read is registered; the summary word follows the end walk.
// Each drain word returns one base (memory read then output register) once
// the output slot is free; masking is applied as the base is read out.
// ----------------------------------------------------------------------------
`include "read_quality_window_trim_defines.svh"

module read_quality_window_trim #(
    parameter int unsigned MAX_READ   = 16384,
    parameter int unsigned MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_base_in,
    input  logic [6:0]  i_quality,
    input  logic        i_last_base,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_base_out,
    output logic        o_is_final,
    output logic [14:0] o_clip_start,
    output logic [14:0] o_clip_end,
    output logic        o_start_found,
    output logic        o_end_found,
    output logic [14:0] o_read_length
);

    localparam int unsigned AW  = $clog2(MAX_READ);
    localparam int unsigned CW  = $clog2(MAX_READ + 1);
    localparam int unsigned WCW = $clog2(MAX_WINDOW + 1);

    // configuration registers
    logic [6:0] r_min_score, r_min_match, r_window_len;
    logic       r_lower_mode;

    // memories
    logic [7:0] base_mem [MAX_READ];
    logic [6:0] qual_mem [MAX_READ];
    logic [7:0] r_base_a;
    logic [6:0] r_qual_a, r_qual_b;

    // control and trim state
    rqwt_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_n, r_didx, r_idx, r_cs, r_ce, r_fpos, r_e;
    logic [WCW-1:0] r_wcnt;
    logic           r_fs, r_fe, r_dlow;
    logic [6:0]     r_dscore;

    // output register
    logic        r_out_valid, r_kind, r_is_final, r_sfound, r_efound;
    logic [7:0]  r_base_out;
    logic [14:0] r_clip_start, r_clip_end, r_read_length;

    // datapath helpers
    logic [WCW-1:0] w_eff;
    logic           out_free, in_acc, load_acc, drain_acc;
    logic [CW-1:0]  load_base, load_n, idx1, didx1;
    logic           load_store;
    logic [31:0]    head;
    logic           g_a, g_b, low_a, win_good, drain_low, drain_mask;
    logic           mem_we;
    logic [AW-1:0]  mem_wa, mem_ra, mem_rb;
    rqwt_pkg::t_state trim_first;

    // effective window length
    always_comb begin
        if (32'(r_window_len) > MAX_WINDOW) begin
            w_eff = WCW'(MAX_WINDOW);
        end else begin
            w_eff = WCW'(r_window_len);
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;
    assign load_acc  = in_acc && (i_cmd == rqwt_pkg::CMD_LOAD);
    assign drain_acc = in_acc && (i_cmd == rqwt_pkg::CMD_DRAIN);

    // a load while draining starts a new read
    assign load_base  = (r_state == rqwt_pkg::ST_DRAIN) ? '0 : r_n;
    assign load_store = 32'(load_base) < MAX_READ;
    assign load_n     = load_store ? load_base + CW'(1) : load_base;

    assign idx1     = r_idx + CW'(1);
    assign didx1    = r_didx + CW'(1);
    assign head     = 32'(r_idx) + 32'(w_eff);
    assign g_a      = r_qual_a > r_min_score;
    assign g_b      = r_qual_b > r_min_score;
    assign low_a    = r_qual_a < r_min_score;
    assign win_good = 32'(r_wcnt) > 32'(r_min_match);

    assign trim_first = (w_eff != '0) ? rqwt_pkg::ST_PRE_RD : rqwt_pkg::ST_SCAN_RD;

    // drain-time masking from the trim results
    assign drain_low  = r_qual_a < r_dscore;
    assign drain_mask = (r_fs && (r_didx < r_fpos || drain_low))
                     || (r_fe && (r_didx > r_e || drain_low));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rqwt_pkg::ST_LOAD: begin
                if (load_acc && i_last_base) begin
                    n_state = trim_first;
                end
            end
            rqwt_pkg::ST_PRE_RD:  n_state = rqwt_pkg::ST_PRE_US;
            rqwt_pkg::ST_PRE_US: begin
                if (32'(idx1) >= 32'(w_eff) || idx1 >= r_n) begin
                    n_state = rqwt_pkg::ST_SCAN_RD;
                end else begin
                    n_state = rqwt_pkg::ST_PRE_RD;
                end
            end
            rqwt_pkg::ST_SCAN_RD: n_state = rqwt_pkg::ST_SCAN_US;
            rqwt_pkg::ST_SCAN_US: begin
                if (idx1 == r_n) begin
                    n_state = rqwt_pkg::ST_CS_RD;
                end else begin
                    n_state = rqwt_pkg::ST_SCAN_RD;
                end
            end
            rqwt_pkg::ST_CS_RD: begin
                if (!r_fs || r_cs == r_n) begin
                    n_state = rqwt_pkg::ST_CE_RD;
                end else begin
                    n_state = rqwt_pkg::ST_CS_US;
                end
            end
            rqwt_pkg::ST_CS_US: n_state = low_a ? rqwt_pkg::ST_CS_RD : rqwt_pkg::ST_CE_RD;
            rqwt_pkg::ST_CE_RD: begin
                if (!r_fe || r_ce == '0) begin
                    n_state = rqwt_pkg::ST_SUM;
                end else begin
                    n_state = rqwt_pkg::ST_CE_US;
                end
            end
            rqwt_pkg::ST_CE_US: n_state = low_a ? rqwt_pkg::ST_CE_RD : rqwt_pkg::ST_SUM;
            rqwt_pkg::ST_SUM: begin
                if (out_free) begin
                    n_state = rqwt_pkg::ST_DRAIN;
                end
            end
            rqwt_pkg::ST_DRAIN: begin
                if (drain_acc) begin
                    n_state = rqwt_pkg::ST_DOUT;
                end else if (load_acc) begin
                    n_state = i_last_base ? trim_first : rqwt_pkg::ST_LOAD;
                end
            end
            rqwt_pkg::ST_DOUT: begin
                if (didx1 >= r_n) begin
                    n_state = rqwt_pkg::ST_LOAD;
                end else begin
                    n_state = rqwt_pkg::ST_DRAIN;
                end
            end
            default: n_state = rqwt_pkg::ST_LOAD;
        endcase
    end

    // handshake and memory port control
    always_comb begin
        o_in_ready = 1'b0;
        mem_ra     = r_didx[AW-1:0];
        unique case (r_state)
            rqwt_pkg::ST_LOAD:  o_in_ready = 1'b1;
            rqwt_pkg::ST_DRAIN: o_in_ready = out_free;
            rqwt_pkg::ST_PRE_RD, rqwt_pkg::ST_SCAN_RD: mem_ra = r_idx[AW-1:0];
            rqwt_pkg::ST_CS_RD: mem_ra = r_cs[AW-1:0];
            rqwt_pkg::ST_CE_RD: mem_ra = r_ce[AW-1:0];
            default: o_in_ready = 1'b0;
        endcase
    end

    assign mem_rb = head[AW-1:0];
    assign mem_we = load_acc && load_store;
    assign mem_wa = load_base[AW-1:0];

    // base and quality memories
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            base_mem[mem_wa] <= rqwt_pkg::to_upper(i_base_in);
            qual_mem[mem_wa] <= i_quality;
        end
        r_base_a <= base_mem[mem_ra];
        r_qual_a <= qual_mem[mem_ra];
        r_qual_b <= qual_mem[mem_rb];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_score  <= 7'd20;
            r_min_match  <= 7'd20;
            r_window_len <= 7'd25;
            r_lower_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rqwt_pkg::CFG_MIN_SCORE:  r_min_score  <= i_cfg_data;
                rqwt_pkg::CFG_MIN_MATCH:  r_min_match  <= i_cfg_data;
                rqwt_pkg::CFG_WINDOW_LEN: r_window_len <= i_cfg_data;
                rqwt_pkg::CFG_LOWER_MODE: r_lower_mode <= i_cfg_data[0];
                default: r_lower_mode <= r_lower_mode;
            endcase
        end
    end

    // controller and trim datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rqwt_pkg::ST_LOAD;
            r_n     <= '0;
            r_didx  <= '0;
            r_fs    <= 1'b0;
            r_fe    <= 1'b0;
        end else begin
            r_state <= n_state;

            // load word: count it, start trimming on the last one
            if (load_acc) begin
                r_n    <= load_n;
                r_didx <= '0;
                if (i_last_base) begin
                    r_idx    <= '0;
                    r_wcnt   <= '0;
                    r_fs     <= 1'b0;
                    r_fe     <= 1'b0;
                    r_cs     <= '0;
                    r_ce     <= load_n - CW'(1);
                    r_dscore <= r_min_score;
                    r_dlow   <= r_lower_mode;
                end
            end

            unique case (r_state)
                // first window count
                rqwt_pkg::ST_PRE_US: begin
                    r_wcnt <= r_wcnt + WCW'(g_a);
                    if (32'(idx1) >= 32'(w_eff) || idx1 >= r_n) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= idx1;
                    end
                end
                // sliding scan: first good window and last full good window
                rqwt_pkg::ST_SCAN_US: begin
                    if (win_good) begin
                        if (!r_fs) begin
                            r_fs   <= 1'b1;
                            r_cs   <= r_idx;
                            r_fpos <= r_idx;
                        end
                        if (head <= 32'(r_n)) begin
                            r_fe <= 1'b1;
                            r_ce <= CW'(head - 32'd1);
                            r_e  <= CW'(head - 32'd1);
                        end
                    end
                    if (w_eff != '0) begin
                        r_wcnt <= r_wcnt - WCW'(g_a)
                                + WCW'(head < 32'(r_n) && g_b);
                    end
                    r_idx <= idx1;
                end
                // start bound walks over low bases
                rqwt_pkg::ST_CS_US: begin
                    if (low_a) begin
                        r_cs <= r_cs + CW'(1);
                    end
                end
                // end bound retreats over low bases
                rqwt_pkg::ST_CE_US: begin
                    if (low_a) begin
                        r_ce <= r_ce - CW'(1);
                    end
                end
                rqwt_pkg::ST_DOUT: begin
                    if (didx1 >= r_n) begin
                        r_n    <= '0;
                        r_didx <= '0;
                    end else begin
                        r_didx <= didx1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == rqwt_pkg::ST_SUM && out_free) begin
                r_out_valid   <= 1'b1;
                r_kind        <= rqwt_pkg::KIND_SUMMARY;
                r_base_out    <= '0;
                r_is_final    <= 1'b0;
                r_clip_start  <= 15'(r_cs);
                r_clip_end    <= 15'(r_ce);
                r_sfound      <= r_fs;
                r_efound      <= r_fe;
                r_read_length <= 15'(r_n);
            end else if (r_state == rqwt_pkg::ST_DOUT) begin
                r_out_valid   <= 1'b1;
                r_kind        <= rqwt_pkg::KIND_BASE;
                r_base_out    <= drain_mask ? rqwt_pkg::mask_base(r_base_a, r_dlow)
                                            : r_base_a;
                r_is_final    <= didx1 >= r_n;
                r_clip_start  <= '0;
                r_clip_end    <= '0;
                r_sfound      <= 1'b0;
                r_efound      <= 1'b0;
                r_read_length <= '0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_base_out    = r_base_out;
    assign o_is_final    = r_is_final;
    assign o_clip_start  = r_clip_start;
    assign o_clip_end    = r_clip_end;
    assign o_start_found = r_sfound;
    assign o_end_found   = r_efound;
    assign o_read_length = r_read_length;

    // checks
    `RQWT_ASSERT_NOW(a_dout_slot_free, r_state == rqwt_pkg::ST_DOUT, !r_out_valid)
    `RQWT_ASSERT_NOW(a_accept_state, in_acc,
        r_state == rqwt_pkg::ST_LOAD || r_state == rqwt_pkg::ST_DRAIN)
    `RQWT_ASSERT_NOW(a_cs_in_read, r_state == rqwt_pkg::ST_CS_US, r_cs < r_n)
    `RQWT_ASSERT_NEXT(a_out_held, r_out_valid && !i_out_ready,
        r_out_valid && $stable(r_base_out) && $stable(r_kind))

endmodule

@@ test/tb_read_quality_window_trim.sv @@
// ----------------------------------------------------------------------------
// Read quality window trim: testbench
// Streams sequencing reads (loads, then drains) through the trimmer under
// several threshold and window settings. Every result word is checked against
// a cycle-free predictor of the trimming passes. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_read_quality_window_trim;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int READ_CAP   = 16384;
    localparam int WIN_CAP    = 64;
    localparam int CYCLE_CAP  = 2000000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic        cmd;
        logic [7:0]  base;
        logic [6:0]  qual;
        logic        last;
    } t_word;

    typedef struct {
        logic        kind;
        logic [7:0]  base;
        logic        fin;
        logic [14:0] cs;
        logic [14:0] ce;
        logic        sf;
        logic        ef;
        logic [14:0] len;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;
    logic        i_in_valid, o_in_ready;
    logic        i_cmd, i_last_base;
    logic [7:0]  i_base_in;
    logic [6:0]  i_quality;
    logic        o_out_valid, i_out_ready;
    logic        o_kind, o_is_final, o_start_found, o_end_found;
    logic [7:0]  o_base_out;
    logic [14:0] o_clip_start, o_clip_end, o_read_length;

    read_quality_window_trim uut (.*);

    // stimulus and expectation stores
    t_word pend_words[$];
    t_res  trim_expect[$];
    int    errors, cycles, reads_sent, bases_seen, summaries_seen;
    bit    hold_req, hold_done;
    int    hold_cnt;

    // predictor state
    logic [7:0] base_mem[READ_CAP];
    logic [6:0] qual_mem[READ_CAP];
    int   loaded, drain_pos;
    bit   draining;
    logic [6:0] score_thr, match_thr, win_len;
    logic       lower_on;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] masked(input logic [7:0] b);
        if (!lower_on) return 8'h4E;
        if (b >= "A" && b <= "Z") return b + 8'd32;
        return b;
    endfunction

    function automatic bit window_ok(input int i, input int n, input int w);
        int stop, cnt;
        stop = (i + w > n) ? n : i + w;
        cnt  = 0;
        for (int j = i; j < stop; j++)
            if (qual_mem[j] > score_thr) cnt++;
        return cnt > match_thr;
    endfunction

    // forward and backward trimming passes over the stored read
    function automatic void trim_read(input int n, output t_res r);
        int w, cs, ce;
        bit fs, fe;
        w  = (win_len > WIN_CAP) ? WIN_CAP : win_len;
        cs = 0;
        ce = (n > 0) ? n - 1 : 0;
        fs = 0;
        fe = 0;
        for (int i = 0; i < n; i++) begin
            if (!fs && window_ok(i, n, w)) begin
                for (int j = 0; j < i; j++) base_mem[j] = masked(base_mem[j]);
                cs = i;
                fs = 1;
            end
            if (fs && qual_mem[i] < score_thr) begin
                base_mem[i] = masked(base_mem[i]);
                if (i == cs) cs++;
            end
        end
        if (w >= 1 && n >= w) begin
            for (int k = n - w; k >= 0; k--) begin
                if (window_ok(k, n, w)) begin
                    ce = k + w - 1;
                    fe = 1;
                    break;
                end
            end
            if (fe) begin
                for (int j = ce + 1; j < n; j++) base_mem[j] = masked(base_mem[j]);
                for (int m = ce; m >= 0; m--) begin
                    if (qual_mem[m] < score_thr) begin
                        base_mem[m] = masked(base_mem[m]);
                        if (m == ce && ce > 0) ce--;
                    end
                end
            end
        end
        r = '{kind: rqwt_pkg::KIND_SUMMARY, base: 8'd0, fin: 1'b0, cs: cs[14:0],
              ce: ce[14:0], sf: fs, ef: fe, len: n[14:0]};
    endfunction

    // advance the predictor by one accepted word
    function automatic void predict_word(input t_word wd);
        t_res r;
        logic [7:0] b;
        if (wd.cmd == rqwt_pkg::CMD_LOAD) begin
            if (draining) begin
                draining  = 0;
                loaded    = 0;
                drain_pos = 0;
            end
            if (loaded < READ_CAP) begin
                b = wd.base;
                if (b >= "a" && b <= "z") b = b - 8'd32;
                base_mem[loaded] = b;
                qual_mem[loaded] = wd.qual;
                loaded++;
            end
            if (wd.last) begin
                trim_read(loaded, r);
                draining  = 1;
                drain_pos = 0;
                trim_expect.push_back(r);
            end
        end else if (draining && drain_pos < loaded) begin
            r = '{kind: rqwt_pkg::KIND_BASE, base: base_mem[drain_pos], fin: 1'b0,
                  cs: '0, ce: '0, sf: 1'b0, ef: 1'b0, len: '0};
            drain_pos++;
            if (drain_pos >= loaded) begin
                r.fin     = 1'b1;
                draining  = 0;
                loaded    = 0;
                drain_pos = 0;
            end
            trim_expect.push_back(r);
        end
    endfunction

    // driver: present queued words, idle now and then
    always @(posedge i_clk) begin
        t_word wd;
        bit    idle;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                predict_word('{cmd: i_cmd, base: i_base_in, qual: i_quality,
                               last: i_last_base});
            if (!i_in_valid || o_in_ready) begin
                idle = (cycles < 4000 || cycles >= 9000) && ($urandom_range(99) < 16);
                if (pend_words.size() > 0 && !idle) begin
                    wd = pend_words.pop_front();
                    i_in_valid  <= 1'b1;
                    i_cmd       <= wd.cmd;
                    i_base_in   <= wd.base;
                    i_quality   <= wd.qual;
                    i_last_base <= wd.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HOLD_LEN) hold_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (cycles >= 4000 && cycles < 9000) || ($urandom_range(99) >= 16);
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (trim_expect.size() == 0) begin
                report("unexpected word kind", o_kind, -1);
            end else begin
                e = trim_expect.pop_front();
                if (o_kind !== e.kind)               report("kind", o_kind, e.kind);
                if (o_base_out !== e.base)           report("base_out", o_base_out, e.base);
                if (o_is_final !== e.fin)            report("is_final", o_is_final, e.fin);
                if (o_clip_start !== e.cs)           report("clip_start", o_clip_start, e.cs);
                if (o_clip_end !== e.ce)             report("clip_end", o_clip_end, e.ce);
                if (o_start_found !== e.sf)          report("start_found", o_start_found, e.sf);
                if (o_end_found !== e.ef)            report("end_found", o_end_found, e.ef);
                if (o_read_length !== e.len)         report("read_length", o_read_length, e.len);
                if (e.kind == rqwt_pkg::KIND_SUMMARY) summaries_seen++;
                else bases_seen++;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rqwt_pkg::CFG_MIN_SCORE:  score_thr = val;
            rqwt_pkg::CFG_MIN_MATCH:  match_thr = val;
            rqwt_pkg::CFG_WINDOW_LEN: win_len   = val;
            default:                  lower_on  = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int s, input int m, input int w, input int lo);
        write_reg(rqwt_pkg::CFG_MIN_SCORE, s[6:0]);
        write_reg(rqwt_pkg::CFG_MIN_MATCH, m[6:0]);
        write_reg(rqwt_pkg::CFG_WINDOW_LEN, w[6:0]);
        write_reg(rqwt_pkg::CFG_LOWER_MODE, lo[6:0]);
    endtask

    task automatic push_word(input logic c, input logic [7:0] b, input logic [6:0] q,
                             input logic l);
        pend_words.push_back('{cmd: c, base: b, qual: q, last: l});
    endtask

    // drain word with random filler in the unused fields
    task automatic push_rand_drain();
        push_word(rqwt_pkg::CMD_DRAIN, 8'($urandom), 7'($urandom), 1'($urandom));
    endtask

    function automatic logic [7:0] pick_base();
        string letters;
        letters = "ACGTNacgtn";
        if ($urandom_range(99) < 80) return letters[$urandom_range(9)];
        return 8'($urandom_range(255));
    endfunction

    // one read: low head, good middle, low tail (or noisy throughout); drained fully unless partial
    task automatic add_read(input int len, input int drains);
        int hi_lo, hi_hi, q;
        bit noisy;
        hi_lo = $urandom_range(len / 3);
        hi_hi = hi_lo + $urandom_range(len);
        noisy = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++) begin
            if (noisy)
                q = $urandom_range(127);
            else if (i >= hi_lo && i <= hi_hi && $urandom_range(9) != 0)
                q = score_thr + $urandom_range(1, 20);
            else
                q = $urandom_range(score_thr);
            if (q > 127) q = 127;
            push_word(rqwt_pkg::CMD_LOAD, pick_base(), q[6:0], i == len - 1);
        end
        for (int i = 0; i < drains; i++) push_rand_drain();
        reads_sent++;
    endtask

    task automatic random_phase(input int target);
        int start, len, d;
        start = pend_words.size();
        while (pend_words.size() - start < target) begin
            if ($urandom_range(19) == 0)
                push_rand_drain();
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 140) : $urandom_range(1, 50);
            case ($urandom_range(9))
                0:       d = $urandom_range(len - 1);
                1:       d = len + $urandom_range(1, 2);
                default: d = len;
            endcase
            add_read(len, d);
        end
        add_read($urandom_range(1, 40), 0);
    endtask

    task automatic finish_drain();
        int n;
        n = 0;
        for (int i = pend_words.size() - 1;
             i >= 0 && pend_words[i].cmd == rqwt_pkg::CMD_LOAD; i--)
            n++;
        for (int i = 0; i < n; i++) push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
    endtask

    task automatic settle();
        while (pend_words.size() > 0 || i_in_valid || trim_expect.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        string seq;
        errors = 0; cycles = 0; reads_sent = 0; bases_seen = 0; summaries_seen = 0;
        hold_req = 0; hold_done = 0; hold_cnt = 0;
        loaded = 0; drain_pos = 0; draining = 0;
        score_thr = 7'd20; match_thr = 7'd20; win_len = 7'd25; lower_on = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_cmd = 1'b0; i_base_in = '0; i_quality = '0;
        i_last_base = 1'b0; i_out_ready = 1'b0;
        seq = "acgtACGT";
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, drain with nothing loaded, field extremes
        push_word(rqwt_pkg::CMD_DRAIN, 8'hFF, 7'h7F, 1'b1);
        push_word(rqwt_pkg::CMD_LOAD, 8'h00, 7'h00, 1'b0);
        push_word(rqwt_pkg::CMD_LOAD, "a", 7'h7F, 1'b0);
        push_word(rqwt_pkg::CMD_LOAD, 8'hFF, 7'd20, 1'b1);
        push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
        // load while draining abandons the read
        push_word(rqwt_pkg::CMD_LOAD, "z", 7'd0, 1'b0);
        push_word(rqwt_pkg::CMD_LOAD, "G", 7'd127, 1'b1);
        push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
        push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
        push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
        settle();
        // directed: loose thresholds, unit window, lower-case masking
        set_all(0, 0, 1, 1);
        for (int i = 0; i < 8; i++)
            push_word(rqwt_pkg::CMD_LOAD, seq[i], i[0] ? 7'd0 : 7'd5, i == 7);
        for (int i = 0; i < 8; i++) push_word(rqwt_pkg::CMD_DRAIN, 8'h00, 7'h00, 1'b0);
        settle();

        // random phases across register settings, extremes first
        set_all(127, 64, 64, 0);
        random_phase(150);
        finish_drain();
        settle();
        set_all(10, 3, 0, 1);           // zero window
        hold_req = 1;                   // long receiver hold-off while loads stream in
        random_phase(150);
        finish_drain();
        settle();
        set_all(15, 5, 100, 0);         // window above the cap
        random_phase(180);
        finish_drain();
        settle();
        set_all(30, 127, 10, 1);
        random_phase(130);
        finish_drain();
        settle();
        for (int p = 0; p < 3; p++) begin
            set_all($urandom_range(40), $urandom_range(12), $urandom_range(1, 30),
                    $urandom_range(1));
            random_phase(170);
            finish_drain();
            settle();
        end

        $display("covered %0d reads, %0d summary words and %0d drained bases",
                 reads_sent + 3, summaries_seen, bases_seen);
        $display("settings ranged over zero, unit, capped and oversized windows");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
